// ----- design/pdog_pkg.sv -----
// Shared types and constants of the pair distance objective and gradient block.
// Used by the front, queue, back and top level files; depends on nothing.
package pdog_pkg;

    localparam int MUL_STEPS  = 32;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [32:0] ONE_Q16   = 33'h0_0001_0000;
    localparam logic [46:0] GRAD_CAP  = {47{1'b1}};
    localparam logic [62:0] ENERGY_CAP = {63{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_POST,
        ST_SQRT,
        ST_EDIFF,
        ST_DIV,
        ST_EMIT
    } pdog_state_t;

    typedef enum logic [3:0] {
        OP_SQ0,
        OP_SQ1,
        OP_SQ2,
        OP_EE,
        OP_EW,
        OP_NUM,
        OP_G0,
        OP_G1,
        OP_G2
    } pdog_op_t;

    typedef struct packed {
        logic [2:0][31:0] vmag;
        logic [2:0]       vneg;
        logic [31:0]      wmag;
        logic             wneg;
        logic [30:0]      target;
        logic             diag;
        logic             row_end;
        logic             done;
        logic [7:0]       row;
    } pdog_pair_t;

    typedef struct packed {
        logic [2:0][47:0] grad;
        logic [7:0]       atom_index;
        logic [63:0]      energy;
        logic             image_done;
    } pdog_result_t;

endpackage

// ----- design/pdog_front.sv -----
// Front part: accepts pair items, forms the separation vector and tracks row and column.
// Depends on pdog_pkg.
module pdog_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [8:0]          atom_limit,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [351:0]        in_data,
    input  logic                queue_full,
    output logic                push,
    output pdog_pkg::pdog_pair_t pair
);

    logic [7:0]         row_reg, row_next;
    logic [7:0]         col_reg, col_next;
    logic signed [33:0] vec_raw [3];
    logic signed [31:0] vec_sat [3];
    logic signed [31:0] w;
    logic               row_end;
    logic               img_end;

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;
    assign w        = in_data[319:288];
    assign row_end  = ({1'b0, col_reg} + 9'd1) >= atom_limit;
    assign img_end  = ({1'b0, row_reg} + 9'd1) >= atom_limit;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            vec_raw[k] = 34'(signed'(in_data[32*k +: 32]))
                       - 34'(signed'(in_data[32*(k+3) +: 32]))
                       - 34'(signed'(in_data[32*(k+6) +: 32]));
            if (vec_raw[k] > 34'sh0_7FFF_FFFF)
                vec_sat[k] = 32'sh7FFF_FFFF;
            else if (vec_raw[k] < -34'sh0_8000_0000)
                vec_sat[k] = 32'sh8000_0000;
            else
                vec_sat[k] = vec_raw[k][31:0];
            pair.vneg[k] = vec_sat[k][31];
            pair.vmag[k] = vec_sat[k][31] ? 32'(-vec_sat[k]) : vec_sat[k];
        end
        pair.wneg    = w[31];
        pair.wmag    = w[31] ? 32'(-w) : w;
        pair.target  = in_data[350:320];
        pair.diag    = row_reg == col_reg;
        pair.row_end = row_end;
        pair.done    = img_end;
        pair.row     = row_reg;
    end

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (push)
        begin
            if (row_end)
            begin
                col_next = 8'd0;
                row_next = img_end ? 8'd0 : row_reg + 8'd1;
            end
            else
            begin
                col_next = col_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= 8'd0;
            col_reg <= 8'd0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

// ----- design/pdog_queue.sv -----
// Two-entry queue of classified pairs between the front and the back part.
// Depends on pdog_pkg.
module pdog_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  pdog_pkg::pdog_pair_t pair_in,
    output logic                 full,
    input  logic                 pop,
    output logic                 pop_valid,
    output pdog_pkg::pdog_pair_t pair_out
);

    localparam int PtrW = $clog2(pdog_pkg::QUEUE_DEPTH);

    pdog_pkg::pdog_pair_t slots [pdog_pkg::QUEUE_DEPTH];
    logic [PtrW-1:0] wr_reg, wr_next;
    logic [PtrW-1:0] rd_reg, rd_next;
    logic [PtrW:0]   count_reg, count_next;

    assign full      = count_reg == (PtrW+1)'(pdog_pkg::QUEUE_DEPTH);
    assign pop_valid = count_reg != '0;
    assign pair_out  = slots[rd_reg];

    always_comb
    begin
        wr_next    = push ? PtrW'(wr_reg + 1'b1) : wr_reg;
        rd_next    = pop ? PtrW'(rd_reg + 1'b1) : rd_reg;
        count_next = count_reg + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_reg] <= pair_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- design/pdog_back.sv -----
// Back part: shared shift-add multiplier, square root and divider sequencer, accumulators
// and the result register. Depends on pdog_pkg.
module pdog_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pop_valid,
    input  pdog_pkg::pdog_pair_t   pair,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output pdog_pkg::pdog_result_t out_result
);

    pdog_pkg::pdog_state_t  state_reg, state_next;
    pdog_pkg::pdog_op_t     op_reg, op_next;
    pdog_pkg::pdog_pair_t   item_reg, item_next;
    pdog_pkg::pdog_result_t out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;
    logic [5:0]             cnt_reg, cnt_next;
    logic [63:0]            work_reg, work_next;
    logic [95:0]            ma_reg, ma_next;
    logic [31:0]            mb_reg, mb_next;
    logic [95:0]            mp_reg, mp_next;
    logic [35:0]            rem_reg, rem_next;
    logic [31:0]            root_reg, root_next;
    logic [31:0]            emag_reg, emag_next;
    logic                   eneg_reg, eneg_next;
    logic [32:0]            den_reg, den_next;
    logic signed [47:0]     grad_reg [3];
    logic signed [47:0]     grad_next [3];
    logic signed [63:0]     energy_reg, energy_next;

    logic                   out_free;
    logic                   mul_last, sqrt_last, div_last;
    logic [1:0]             sel_k;
    logic [31:0]            sel_mag;
    logic [63:0]            a_sel;
    logic [31:0]            b_sel;
    logic [32:0]            den_calc;
    logic [35:0]            sq_shift, sq_trial;
    logic [33:0]            dv_shift;
    logic                   dv_geq;
    logic [32:0]            ediff;
    logic [62:0]            e_mag;
    logic signed [63:0]     e_term;
    logic signed [64:0]     e_sum;
    logic signed [63:0]     e_sat;
    logic [46:0]            g_mag;
    logic                   g_neg;
    logic signed [47:0]     g_term;
    logic signed [48:0]     g_sum;
    logic signed [47:0]     g_sat;

    assign out_free   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;
    assign pop        = (state_reg == pdog_pkg::ST_IDLE) && pop_valid;
    assign mul_last   = cnt_reg == 6'(pdog_pkg::MUL_STEPS - 1);
    assign sqrt_last  = cnt_reg == 6'(pdog_pkg::SQRT_STEPS - 1);
    assign div_last   = cnt_reg == 6'(pdog_pkg::DIV_STEPS - 1);
    assign den_calc   = {1'b0, root_reg} + (item_reg.diag ? pdog_pkg::ONE_Q16 : 33'd0);

    always_comb
    begin
        unique case (op_reg)
            pdog_pkg::OP_SQ1, pdog_pkg::OP_G1: sel_k = 2'd1;
            pdog_pkg::OP_SQ2, pdog_pkg::OP_G2: sel_k = 2'd2;
            default:                           sel_k = 2'd0;
        endcase
        sel_mag = item_reg.vmag[sel_k];
        unique case (op_reg)
            pdog_pkg::OP_SQ0, pdog_pkg::OP_SQ1, pdog_pkg::OP_SQ2:
            begin
                a_sel = {32'd0, sel_mag};
                b_sel = sel_mag;
            end
            pdog_pkg::OP_EE:
            begin
                a_sel = {32'd0, emag_reg};
                b_sel = emag_reg;
            end
            pdog_pkg::OP_NUM:
            begin
                a_sel = {32'd0, emag_reg};
                b_sel = item_reg.wmag;
            end
            pdog_pkg::OP_EW:
            begin
                a_sel = work_reg;
                b_sel = item_reg.wmag;
            end
            default:
            begin
                a_sel = work_reg;
                b_sel = sel_mag;
            end
        endcase
    end

    always_comb
    begin
        sq_shift = {rem_reg[33:0], work_reg[63:62]};
        sq_trial = {2'b00, root_reg, 2'b01};
        dv_shift = {rem_reg[32:0], work_reg[63]};
        dv_geq   = dv_shift >= {1'b0, den_reg};
        ediff    = {1'b0, root_reg} - {2'b00, item_reg.target};

        e_mag  = mp_reg[95] ? pdog_pkg::ENERGY_CAP : mp_reg[94:32];
        e_term = item_reg.wneg ? -$signed({1'b0, e_mag}) : $signed({1'b0, e_mag});
        e_sum  = {energy_reg[63], energy_reg} + {e_term[63], e_term};
        if (e_sum[64] != e_sum[63])
            e_sat = e_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else
            e_sat = e_sum[63:0];

        g_mag  = (|mp_reg[95:63]) ? pdog_pkg::GRAD_CAP : mp_reg[62:16];
        g_neg  = (eneg_reg != item_reg.wneg) != item_reg.vneg[sel_k];
        g_term = g_neg ? -$signed({1'b0, g_mag}) : $signed({1'b0, g_mag});
        g_sum  = {grad_reg[sel_k][47], grad_reg[sel_k]} + {g_term[47], g_term};
        if (g_sum[48] != g_sum[47])
            g_sat = g_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        else
            g_sat = g_sum[47:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pdog_pkg::ST_IDLE:  if (pop_valid) state_next = pdog_pkg::ST_LOAD;
            pdog_pkg::ST_LOAD:  state_next = pdog_pkg::ST_MUL;
            pdog_pkg::ST_MUL:   if (mul_last) state_next = pdog_pkg::ST_POST;
            pdog_pkg::ST_POST:
            begin
                unique case (op_reg)
                    pdog_pkg::OP_SQ2: state_next = pdog_pkg::ST_SQRT;
                    pdog_pkg::OP_NUM:
                        state_next = (den_calc == 33'd0) ? pdog_pkg::ST_LOAD : pdog_pkg::ST_DIV;
                    pdog_pkg::OP_G2:
                        state_next = item_reg.row_end ? pdog_pkg::ST_EMIT : pdog_pkg::ST_IDLE;
                    default:          state_next = pdog_pkg::ST_LOAD;
                endcase
            end
            pdog_pkg::ST_SQRT:  if (sqrt_last) state_next = pdog_pkg::ST_EDIFF;
            pdog_pkg::ST_EDIFF: state_next = pdog_pkg::ST_LOAD;
            pdog_pkg::ST_DIV:   if (div_last) state_next = pdog_pkg::ST_LOAD;
            pdog_pkg::ST_EMIT:  if (out_free) state_next = pdog_pkg::ST_IDLE;
            default:            state_next = pdog_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        op_next        = op_reg;
        item_next      = item_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cnt_next       = cnt_reg;
        work_next      = work_reg;
        ma_next        = ma_reg;
        mb_next        = mb_reg;
        mp_next        = mp_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        emag_next      = emag_reg;
        eneg_next      = eneg_reg;
        den_next       = den_reg;
        grad_next      = grad_reg;
        energy_next    = energy_reg;
        unique case (state_reg)
            pdog_pkg::ST_IDLE:
            begin
                if (pop_valid)
                begin
                    item_next = pair;
                    op_next   = pdog_pkg::OP_SQ0;
                    work_next = 64'd0;
                end
            end
            pdog_pkg::ST_LOAD:
            begin
                ma_next  = {32'd0, a_sel};
                mb_next  = b_sel;
                mp_next  = 96'd0;
                cnt_next = 6'd0;
            end
            pdog_pkg::ST_MUL:
            begin
                mp_next  = mp_reg + (mb_reg[0] ? ma_reg : 96'd0);
                ma_next  = {ma_reg[94:0], 1'b0};
                mb_next  = {1'b0, mb_reg[31:1]};
                cnt_next = cnt_reg + 6'd1;
            end
            pdog_pkg::ST_POST:
            begin
                unique case (op_reg)
                    pdog_pkg::OP_SQ0:
                    begin
                        work_next = work_reg + mp_reg[63:0];
                        op_next   = pdog_pkg::OP_SQ1;
                    end
                    pdog_pkg::OP_SQ1:
                    begin
                        work_next = work_reg + mp_reg[63:0];
                        op_next   = pdog_pkg::OP_SQ2;
                    end
                    pdog_pkg::OP_SQ2:
                    begin
                        work_next = work_reg + mp_reg[63:0];
                        rem_next  = 36'd0;
                        root_next = 32'd0;
                        cnt_next  = 6'd0;
                    end
                    pdog_pkg::OP_EE:
                    begin
                        work_next = mp_reg[63:0];
                        op_next   = pdog_pkg::OP_EW;
                    end
                    pdog_pkg::OP_EW:
                    begin
                        energy_next = e_sat;
                        op_next     = pdog_pkg::OP_NUM;
                    end
                    pdog_pkg::OP_NUM:
                    begin
                        den_next = den_calc;
                        rem_next = 36'd0;
                        cnt_next = 6'd0;
                        if (den_calc == 33'd0)
                        begin
                            work_next = 64'd0;
                            op_next   = pdog_pkg::OP_G0;
                        end
                        else
                        begin
                            work_next = mp_reg[63:0];
                        end
                    end
                    pdog_pkg::OP_G0:
                    begin
                        grad_next[0] = g_sat;
                        op_next      = pdog_pkg::OP_G1;
                    end
                    pdog_pkg::OP_G1:
                    begin
                        grad_next[1] = g_sat;
                        op_next      = pdog_pkg::OP_G2;
                    end
                    default:
                    begin
                        grad_next[2] = g_sat;
                    end
                endcase
            end
            pdog_pkg::ST_SQRT:
            begin
                if (sq_shift >= sq_trial)
                begin
                    rem_next  = sq_shift - sq_trial;
                    root_next = {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next  = sq_shift;
                    root_next = {root_reg[30:0], 1'b0};
                end
                work_next = {work_reg[61:0], 2'b00};
                cnt_next  = cnt_reg + 6'd1;
            end
            pdog_pkg::ST_EDIFF:
            begin
                eneg_next = ediff[32];
                emag_next = ediff[32] ? 32'(-ediff) : ediff[31:0];
                op_next   = pdog_pkg::OP_EE;
            end
            pdog_pkg::ST_DIV:
            begin
                rem_next  = {2'b00, dv_geq ? dv_shift - {1'b0, den_reg} : dv_shift};
                work_next = {work_reg[62:0], dv_geq};
                cnt_next  = cnt_reg + 6'd1;
                if (div_last)
                    op_next = pdog_pkg::OP_G0;
            end
            pdog_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_next.grad[0]    = grad_reg[0];
                    out_next.grad[1]    = grad_reg[1];
                    out_next.grad[2]    = grad_reg[2];
                    out_next.atom_index = item_reg.row;
                    out_next.energy     = item_reg.done ? energy_reg : 64'd0;
                    out_next.image_done = item_reg.done;
                    out_valid_next      = 1'b1;
                    grad_next           = '{default: '0};
                    if (item_reg.done)
                        energy_next = 64'sd0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pdog_pkg::ST_IDLE;
            op_reg        <= pdog_pkg::OP_SQ0;
            item_reg      <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= 6'd0;
            work_reg      <= 64'd0;
            ma_reg        <= 96'd0;
            mb_reg        <= 32'd0;
            mp_reg        <= 96'd0;
            rem_reg       <= 36'd0;
            root_reg      <= 32'd0;
            emag_reg      <= 32'd0;
            eneg_reg      <= 1'b0;
            den_reg       <= 33'd0;
            grad_reg      <= '{default: '0};
            energy_reg    <= 64'sd0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            item_reg      <= item_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            work_reg      <= work_next;
            ma_reg        <= ma_next;
            mb_reg        <= mb_next;
            mp_reg        <= mp_next;
            rem_reg       <= rem_next;
            root_reg      <= root_next;
            emag_reg      <= emag_next;
            eneg_reg      <= eneg_next;
            den_reg       <= den_next;
            grad_reg      <= grad_next;
            energy_reg    <= energy_next;
        end
    end

    a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pdog_pkg::ST_MUL) |-> !cnt_reg[5])
        else $error("multiplier step count out of range");

    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pdog_pkg::ST_EMIT && out_valid_reg && !out_ready)
        |=> (state_reg == pdog_pkg::ST_EMIT))
        else $error("result issued while the previous one was still pending");

    a_rise_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == pdog_pkg::ST_EMIT))
        else $error("result register loaded outside the emit step");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == pdog_pkg::ST_LOAD && op_reg == pdog_pkg::OP_SQ0))
        else $error("pair taken from the queue without starting its work");

endmodule

// ----- design/pair_distance_objective_gradient.sv -----
// Top level of the pair distance objective and gradient block: configuration register,
// front part, queue and back part. Depends on pdog_pkg, pdog_front, pdog_queue, pdog_back.
//
//   Channel   Direction  Handshake            Payload
//   cfg       in         cfg_valid/cfg_ready  cfg_data: atom_count
//   s_axis    in         tvalid/tready        tdata: pos_i xyz, pos_j xyz, shift xyz, weight,
//                                             target_distance
//   m_axis    out        tvalid/tready        tdata: grad xyz, atom_index, energy; tlast: image_done
//
// In the back part each pair is taken from the queue and goes through nine multiplier passes
// (load, 32 shift-add steps, post), a 32-step square root, one step for the distance error and
// a 64-step divider, which is skipped when the divisor is zero.
// A pair that ends a row also passes through the emit step, which loads the result register.
// The front part accepts a pair whenever the two-entry queue has room.
// Reset clears the counters and accumulators and sets atom_count to 1; there is no clearing pass.
// A stalled result transfer holds the back part in its emit step; the queue keeps filling.
module pair_distance_objective_gradient #(
    parameter int MAX_ATOMS = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [8:0]   cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_i_x, pos_i_y, pos_i_z, pos_j_x, pos_j_y, pos_j_z, shift_x, shift_y, shift_z,
    // weight, target_distance, then one zero bit
    input  logic [351:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // grad_x, grad_y, grad_z, atom_index, energy
    output logic [215:0] m_axis_tdata,
    output logic         m_axis_tlast
);

    localparam int CountLimit = (MAX_ATOMS < 256) ? MAX_ATOMS : 256;

    logic [8:0]             atom_count_reg, atom_count_next;
    logic [8:0]             atom_limit;
    logic                   queue_full;
    logic                   push;
    logic                   pop;
    logic                   pop_valid;
    pdog_pkg::pdog_pair_t   pair_in;
    pdog_pkg::pdog_pair_t   pair_out;
    pdog_pkg::pdog_result_t result;

    assign cfg_ready       = 1'b1;
    assign atom_count_next = cfg_valid ? cfg_data : atom_count_reg;

    always_comb
    begin
        if (atom_count_reg == 9'd0)
            atom_limit = 9'd1;
        else if (atom_count_reg > 9'(CountLimit))
            atom_limit = 9'(CountLimit);
        else
            atom_limit = atom_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            atom_count_reg <= 9'd1;
        else
            atom_count_reg <= atom_count_next;
    end

    pdog_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .atom_limit (atom_limit),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .queue_full (queue_full),
        .push       (push),
        .pair       (pair_in)
    );

    pdog_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pair_in   (pair_in),
        .full      (queue_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pair_out  (pair_out)
    );

    pdog_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pair       (pair_out),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    assign m_axis_tdata = {result.energy, result.atom_index,
                           result.grad[2], result.grad[1], result.grad[0]};
    assign m_axis_tlast = result.image_done;

endmodule

// ----- tb/pdog_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for pair_distance_objective_gradient: watches the configuration, pair and result
// channels, predicts each atom gradient and image energy, and compares them field by field.
module pdog_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [8:0]   cfg_data,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [351:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [215:0] m_axis_tdata,
    input  logic         m_axis_tlast,
    output int           failures,
    output int           pending,
    output int           checked
);

    localparam longint GRAD_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint GRAD_MIN = -64'sh0000_7FFF_FFFF_FFFF - 1;
    localparam longint ENERGY_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint ENERGY_MIN = -64'sh7FFF_FFFF_FFFF_FFFF - 1;

    typedef struct packed {
        logic [47:0] grad_x;
        logic [47:0] grad_y;
        logic [47:0] grad_z;
        logic [7:0]  atom_index;
        logic [63:0] energy;
        logic        image_done;
    } atom_gradient_t;

    atom_gradient_t gradients_due[$];
    logic [8:0]     atom_count;
    logic [7:0]     row_index;
    logic [7:0]     column_index;
    longint         grad_sum [3];
    longint         energy_sum;

    function automatic longint coord(input logic [351:0] d, input int idx);
        logic signed [31:0] v;
        v = d[32*idx +: 32];
        return v;
    endfunction

    function automatic longint clamp32(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint unsigned magnitude(input longint x);
        return x < 0 ? 64'd0 - 64'(x) : 64'(x);
    endfunction

    function automatic longint unsigned prod_shift(input longint unsigned a,
                                                   input longint unsigned b, input int s);
        logic [127:0] p;
        logic [127:0] q;
        p = {64'd0, a} * {64'd0, b};
        q = p >> s;
        if (q[127:64] != 0) return 64'hFFFF_FFFF_FFFF_FFFF;
        return q[63:0];
    endfunction

    function automatic longint cap_sign(input bit neg, input longint unsigned m,
                                        input longint unsigned cap);
        if (m > cap) m = cap;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic accumulate_pair(input logic [351:0] d);
        longint          vec [3];
        longint unsigned vmag [3];
        longint unsigned sumsq;
        longint unsigned pair_len;
        longint unsigned den;
        longint unsigned emag;
        longint unsigned wmag;
        longint unsigned aux;
        longint          e;
        longint          w;
        longint          term;
        longint          g;
        bit              eneg;
        bit              wneg;
        int              n;
        atom_gradient_t  r;
        n = atom_count;
        if (n < 1) n = 1;
        if (n > 256) n = 256;
        sumsq = 0;
        for (int k = 0; k < 3; k++)
        begin
            vec[k] = clamp32(coord(d, k) - coord(d, 3 + k) - coord(d, 6 + k));
            vmag[k] = magnitude(vec[k]);
            sumsq = sumsq + vmag[k] * vmag[k];
        end
        pair_len = int_sqrt(sumsq);
        w = coord(d, 9);
        e = longint'(pair_len) - longint'({33'd0, d[350:320]});
        eneg = e < 0;
        wneg = w < 0;
        emag = magnitude(e);
        wmag = magnitude(w);
        term = cap_sign(wneg, prod_shift(emag * emag, wmag, 32), 64'h7FFF_FFFF_FFFF_FFFF);
        if (term > 0 && energy_sum > ENERGY_MAX - term) energy_sum = ENERGY_MAX;
        else if (term < 0 && energy_sum < ENERGY_MIN - term) energy_sum = ENERGY_MIN;
        else energy_sum = energy_sum + term;
        den = pair_len + ((row_index == column_index) ? 64'd65536 : 64'd0);
        aux = (den != 0) ? (emag * wmag) / den : 64'd0;
        for (int k = 0; k < 3; k++)
        begin
            g = cap_sign((eneg != wneg) != (vec[k] < 0), prod_shift(aux, vmag[k], 16),
                         64'(GRAD_MAX));
            g = g + grad_sum[k];
            if (g > GRAD_MAX) g = GRAD_MAX;
            if (g < GRAD_MIN) g = GRAD_MIN;
            grad_sum[k] = g;
        end
        if (int'(column_index) + 1 < n)
        begin
            column_index = column_index + 8'd1;
        end
        else
        begin
            r.grad_x = grad_sum[0][47:0];
            r.grad_y = grad_sum[1][47:0];
            r.grad_z = grad_sum[2][47:0];
            r.atom_index = row_index;
            r.image_done = int'(row_index) + 1 >= n;
            r.energy = r.image_done ? energy_sum : 64'd0;
            gradients_due = {gradients_due, r};
            pending = pending + 1;
            for (int k = 0; k < 3; k++) grad_sum[k] = 0;
            column_index = 8'd0;
            if (r.image_done)
            begin
                row_index = 8'd0;
                energy_sum = 0;
            end
            else
            begin
                row_index = row_index + 8'd1;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            failures = failures + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        atom_gradient_t r;
        if (!rst_n)
        begin
            atom_count = 9'd1;
            row_index = 8'd0;
            column_index = 8'd0;
            for (int k = 0; k < 3; k++) grad_sum[k] = 0;
            energy_sum = 0;
            gradients_due.delete();
            failures = 0;
            pending = 0;
            checked = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (gradients_due.size() == 0)
                begin
                    $error("result transfer with no gradient outstanding");
                    failures = failures + 1;
                end
                else
                begin
                    r = gradients_due.pop_front();
                    pending = pending - 1;
                    checked = checked + 1;
                    check_field("grad_x", {16'd0, r.grad_x}, {16'd0, m_axis_tdata[47:0]});
                    check_field("grad_y", {16'd0, r.grad_y}, {16'd0, m_axis_tdata[95:48]});
                    check_field("grad_z", {16'd0, r.grad_z}, {16'd0, m_axis_tdata[143:96]});
                    check_field("atom_index", {56'd0, r.atom_index},
                                {56'd0, m_axis_tdata[151:144]});
                    check_field("energy", r.energy, m_axis_tdata[215:152]);
                    check_field("image_done", {63'd0, r.image_done}, {63'd0, m_axis_tlast});
                end
            end
            if (cfg_valid && cfg_ready) atom_count = cfg_data;
            if (s_axis_tvalid && s_axis_tready) accumulate_pair(s_axis_tdata);
        end
    end

endmodule

// ----- tb/pair_distance_objective_gradient_tb.sv -----
`timescale 1ns / 1ps
// Top of the pair_distance_objective_gradient testbench: clock, reset, pair and configuration
// stimulus and the verdict. Depends on the block and on pdog_checker.
module pair_distance_objective_gradient_tb;

    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;
    localparam logic [31:0] Q_ONE = 32'h0001_0000;

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [8:0]   cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [351:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [215:0] m_axis_tdata;
    logic         m_axis_tlast;
    int           failures;
    int           pending;
    int           checked;
    int           pairs_sent;
    bit           steady;
    bit           hold_request;

    pair_distance_objective_gradient dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    pdog_checker scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .failures      (failures),
        .pending       (pending),
        .checked       (checked)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #50_000_000;
        $display("pair_distance_objective_gradient regression: fail");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [31:0] rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom;
        if (r == 1) return (($urandom_range(0, 1) == 0) ? Q_MAX : Q_MIN);
        return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
    endfunction

    function automatic logic [31:0] rand_shift();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return 32'd0;
        if (r == 5) return $urandom;
        return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
    endfunction

    function automatic logic [30:0] rand_target();
        int r;
        logic [31:0] v;
        r = $urandom_range(0, 9);
        v = $urandom;
        if (r == 0) return v[30:0];
        if (r == 1) return 31'h7FFF_FFFF;
        return 31'($urandom_range(0, 32'h0020_0000));
    endfunction

    // Receiver side: random stalls, plus one long hold-off when requested.
    initial
    begin
        bit lvl;
        int n;
        m_axis_tready = 1'b0;
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                lvl = 1'b0;
                n = 3000;
            end
            else if (steady)
            begin
                lvl = 1'b1;
                n = 1;
            end
            else
            begin
                lvl = $urandom_range(0, 3) != 0;
                n = lvl ? $urandom_range(1, 8) : idle_len();
                if (n < 1) n = 1;
            end
            @(posedge clk);
            m_axis_tready <= lvl;
            repeat (n - 1) @(posedge clk);
        end
    end

    task automatic send_pair(input logic [9:0][31:0] f, input logic [30:0] tgt);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, tgt, f};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        pairs_sent = pairs_sent + 1;
        gap = steady ? 0 : idle_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random_pair(input bit diag);
        logic [9:0][31:0] f;
        for (int k = 0; k < 10; k++) f[k] = (k >= 6 && k < 9) ? rand_shift() : rand_coord();
        if ($urandom_range(0, 5) == 0)
        begin
            // coincident atoms without shift give a zero distance
            f[5:3] = f[2:0];
            f[8:6] = '0;
        end
        else if (diag && $urandom_range(0, 1) == 0)
        begin
            f[5:3] = f[2:0];
        end
        send_pair(f, rand_target());
    endtask

    task automatic send_image(input int n);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                send_random_pair(r == c);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (500) @(posedge clk);
    endtask

    task automatic write_count(input logic [8:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [9:0][31:0] f;
        int n;
        bit held;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        pairs_sent = 0;
        steady = 1'b0;
        hold_request = 1'b0;
        held = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // One atom per image after reset: every pair is a diagonal pair and ends an image.
        f = '0;
        f[9] = Q_ONE;
        send_pair(f, 31'd0);
        f[2:0] = {Q_MAX, Q_MAX, Q_MAX};
        f[5:3] = {Q_MIN, Q_MIN, Q_MIN};
        send_pair(f, 31'd0);
        f[2:0] = {Q_MIN, Q_MIN, Q_MIN};
        f[5:3] = {Q_MAX, Q_MAX, Q_MAX};
        f[9] = Q_MIN;
        send_pair(f, 31'h7FFF_FFFF);
        f = '0;
        f[8:6] = {Q_MAX, Q_MIN, Q_MAX};
        f[9] = Q_MAX;
        send_pair(f, 31'h7FFF_FFFF);
        f[8:6] = {Q_MIN, Q_MAX, Q_MIN};
        send_pair(f, 31'd0);
        f = {10{32'hFFFF_FFFF}};
        send_pair(f, 31'h7FFF_FFFF);
        settle();

        // A count of zero behaves as one.
        write_count(9'd0);
        send_random_pair(1'b1);
        send_random_pair(1'b1);
        settle();

        // Two atoms, with a zero distance off the diagonal.
        write_count(9'd2);
        f = '0;
        f[2:0] = {Q_ONE, Q_ONE, Q_ONE};
        f[9] = Q_ONE;
        send_pair(f, 31'd65536);
        f[5:3] = f[2:0];
        send_pair(f, 31'd65536);
        send_random_pair(1'b0);
        send_random_pair(1'b1);
        settle();

        // Three atoms of far-apart pairs with extreme weights to drive the sums into saturation.
        write_count(9'd3);
        f = '0;
        f[2:0] = {Q_MAX, Q_MAX, Q_MAX};
        f[5:3] = {Q_MIN, Q_MIN, Q_MIN};
        f[9] = Q_MAX;
        repeat (5) send_pair(f, 31'd0);
        f[9] = Q_MIN;
        repeat (4) send_pair(f, 31'd0);
        settle();

        while (pairs_sent < 1000)
        begin
            n = ($urandom_range(0, 7) == 0) ? 12 : $urandom_range(1, 8);
            steady = $urandom_range(0, 4) == 0;
            write_count(9'(n));
            if (!held && pairs_sent > 400 && n > 1)
            begin
                steady = 1'b0;
                hold_request = 1'b1;
                held = 1'b1;
            end
            repeat ($urandom_range(1, 3)) send_image(n);
            settle();
        end
        steady = 1'b0;

        // Largest count: one full row, then the count is lowered in the middle of the image.
        write_count(9'h1FF);
        for (int c = 0; c < 256; c++) send_random_pair(c == 0);
        settle();
        write_count(9'd2);
        send_random_pair(1'b0);
        send_random_pair(1'b1);
        settle();

        $display("Sent %0d atom pairs over counts 0 to 511; checked %0d gradient results.",
                 pairs_sent, checked);
        if (failures == 0)
        begin
            $display("pair_distance_objective_gradient regression: pass");
        end
        else
        begin
            $display("pair_distance_objective_gradient regression: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/pdog_pkg.sv
design/pdog_front.sv
design/pdog_queue.sv
design/pdog_back.sv
design/pair_distance_objective_gradient.sv
tb/pdog_checker.sv
tb/pair_distance_objective_gradient_tb.sv
